### rtl/trsm_pkg.sv
// Shared types and codes for the two-register stack machine.
`default_nettype none

package trsm_pkg;

  localparam int OpW = 3;
  localparam int SelW = 2;
  localparam int StatusW = 2;

  localparam logic [OpW-1:0] OP_ADD  = 3'd0;
  localparam logic [OpW-1:0] OP_SUB  = 3'd1;
  localparam logic [OpW-1:0] OP_MUL  = 3'd2;
  localparam logic [OpW-1:0] OP_DIV  = 3'd3;
  localparam logic [OpW-1:0] OP_MOV  = 3'd4;
  localparam logic [OpW-1:0] OP_PUSH = 3'd5;
  localparam logic [OpW-1:0] OP_POP  = 3'd6;
  localparam logic [OpW-1:0] OP_NOP  = 3'd7;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_DIVZERO   = 2'd1;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_fn_e;

endpackage

`default_nettype wire

### rtl/trsm_addsub.sv
// Shared adder/subtractor used by every arithmetic step of the sequencer.
`default_nettype none

module trsm_addsub import trsm_pkg::*; #(
  parameter int Width = 65
) (
  input  wire logic [Width-1:0] x_i,
  input  wire logic [Width-1:0] y_i,
  input  wire alu_fn_e          fn_i,
  output logic      [Width-1:0] sum_o
);

  logic [Width-1:0] y_eff;

  assign y_eff = (fn_i == ALU_SUB) ? ~y_i : y_i;
  assign sum_o = x_i + y_eff + {{(Width-1){1'b0}}, (fn_i == ALU_SUB)};

endmodule

`default_nettype wire

### rtl/two_register_stack_machine_core.sv
// Top level: sequencer, accumulators, word stack and shared adder of the stack machine.
// Add, sub, mov, push, no-op, ignored codes and flagged cases pass EXEC then FIN; pop
// goes EXEC, POP, FIN; mul and div iterate in ITER, one step per cycle on the shared adder.
// The input stalls until the result is registered and the sequencer is back in IDLE, so a
// new item waits for the previous one to finish, and longer while a previous result is held.
// Reset clears the accumulators, stack fill and output valid; stack words stay undefined.
`default_nettype none

module two_register_stack_machine_core import trsm_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int WORD_BITS   = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [OpW-1:0]                     operation_i,
  input  wire logic [SelW-1:0]                    reg_select_i,
  input  wire logic [WORD_BITS-1:0]               immediate_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [WORD_BITS-1:0]                    acc_a_value_o,
  output logic [WORD_BITS-1:0]                    acc_b_value_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]        stack_used_o,
  output logic [StatusW-1:0]                      status_o
);

  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int StepW = $clog2(WORD_BITS);
  localparam logic [StepW-1:0] LastStep = StepW'(WORD_BITS - 1);
  localparam logic [CntW-1:0]  Depth    = CntW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ITER = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [WORD_BITS-1:0] acc_a_q, acc_a_d;
  logic [WORD_BITS-1:0] acc_b_q, acc_b_d;
  logic                 out_valid_q, out_valid_d;

  logic [OpW-1:0]       op_q, op_d;
  logic [SelW-1:0]      sel_q, sel_d;
  logic [WORD_BITS-1:0] imm_q, imm_d;
  logic [WORD_BITS-1:0] work_a_q, work_a_d;
  logic [WORD_BITS-1:0] work_b_q, work_b_d;
  logic [StatusW-1:0]   status_q, status_d;

  logic [WORD_BITS-1:0] out_a_q, out_a_d;
  logic [WORD_BITS-1:0] out_b_q, out_b_d;
  logic [CntW-1:0]      out_cnt_q, out_cnt_d;
  logic [StatusW-1:0]   out_st_q, out_st_d;

  logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 mem_we;
  logic                 rd_en;
  logic [CntW-1:0]      pop_idx;

  logic [WORD_BITS:0]   alu_x, alu_y, alu_sum;
  alu_fn_e              alu_fn;
  logic [WORD_BITS:0]   div_shift;

  logic                 tgt_ok;
  logic [WORD_BITS-1:0] acc_tgt;
  logic                 wb_en;
  logic [WORD_BITS-1:0] wb_val;

  trsm_addsub #(
    .Width(WORD_BITS + 1)
  ) u_addsub (
    .x_i  (alu_x),
    .y_i  (alu_y),
    .fn_i (alu_fn),
    .sum_o(alu_sum)
  );

  assign tgt_ok    = ~sel_q[1];
  assign acc_tgt   = sel_q[0] ? acc_b_q : acc_a_q;
  assign div_shift = {work_a_q, work_b_q[WORD_BITS-1]};
  assign pop_idx   = count_q - CntW'(1);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    acc_a_d     = acc_a_q;
    acc_b_d     = acc_b_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    sel_d       = sel_q;
    imm_d       = imm_q;
    work_a_d    = work_a_q;
    work_b_d    = work_b_q;
    status_d    = status_q;
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    alu_fn      = ALU_ADD;
    alu_x       = {1'b0, acc_tgt};
    alu_y       = {1'b0, imm_q};
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    wb_en       = 1'b0;
    wb_val      = imm_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          sel_d   = reg_select_i;
          imm_d   = immediate_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        state_d  = S_FIN;
        if (op_q == OP_PUSH) begin
          if (count_q >= Depth) begin
            status_d = ST_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end else if (tgt_ok) begin
          case (op_q)
            OP_ADD: begin
              wb_en  = 1'b1;
              wb_val = alu_sum[WORD_BITS-1:0];
            end
            OP_SUB: begin
              alu_fn = ALU_SUB;
              wb_en  = 1'b1;
              wb_val = alu_sum[WORD_BITS-1:0];
            end
            OP_MUL: begin
              work_a_d = '0;
              work_b_d = acc_tgt;
              step_d   = '0;
              state_d  = S_ITER;
            end
            OP_DIV: begin
              if (imm_q == '0) begin
                status_d = ST_DIVZERO;
              end else begin
                work_a_d = '0;
                work_b_d = acc_tgt;
                step_d   = '0;
                state_d  = S_ITER;
              end
            end
            OP_MOV: begin
              wb_en  = 1'b1;
              wb_val = imm_q;
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = ST_UNDERFLOW;
              end else begin
                rd_en   = 1'b1;
                state_d = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ITER: begin
        if (op_q == OP_DIV) begin
          alu_fn = ALU_SUB;
          alu_x  = div_shift;
          alu_y  = {1'b0, imm_q};
          if (!alu_sum[WORD_BITS]) begin
            work_a_d = alu_sum[WORD_BITS-1:0];
          end else begin
            work_a_d = div_shift[WORD_BITS-1:0];
          end
          work_b_d = {work_b_q[WORD_BITS-2:0], ~alu_sum[WORD_BITS]};
        end else begin
          alu_x = {1'b0, work_a_q};
          alu_y = {1'b0, work_b_q};
          if (imm_q[0]) begin
            work_a_d = alu_sum[WORD_BITS-1:0];
          end
          work_b_d = {work_b_q[WORD_BITS-2:0], 1'b0};
          imm_d    = {1'b0, imm_q[WORD_BITS-1:1]};
        end
        step_d = step_q + StepW'(1);
        if (step_q == LastStep) begin
          wb_en   = 1'b1;
          wb_val  = (op_q == OP_DIV) ? work_b_d : work_a_d;
          state_d = S_FIN;
        end
      end
      S_POP: begin
        wb_en   = 1'b1;
        wb_val  = rd_data_q;
        count_d = pop_idx;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_a_d     = acc_a_q;
          out_b_d     = acc_b_q;
          out_cnt_d   = count_q;
          out_st_d    = status_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (wb_en) begin
      if (sel_q[0]) begin
        acc_b_d = wb_val;
      end else begin
        acc_a_d = wb_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      acc_a_q     <= '0;
      acc_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      acc_a_q     <= acc_a_d;
      acc_b_q     <= acc_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    sel_q     <= sel_d;
    imm_q     <= imm_d;
    work_a_q  <= work_a_d;
    work_b_q  <= work_b_d;
    status_q  <= status_d;
    out_a_q   <= out_a_d;
    out_b_q   <= out_b_d;
    out_cnt_q <= out_cnt_d;
    out_st_q  <= out_st_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[count_q[AddrW-1:0]] <= imm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= stack_mem[pop_idx[AddrW-1:0]];
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign acc_a_value_o = out_a_q;
  assign acc_b_value_o = out_b_q;
  assign stack_used_o  = out_cnt_q;
  assign status_o      = out_st_q;

endmodule

`default_nettype wire
